[src/clws_pkg.sv]
// ----------------------------------------------------------------------------
// clws_pkg: shared types and constants of the character LCD write sequencer
// Item, result, queue entry and register file types, opcode and class codes,
// and the reciprocal constants used to split a reading into decimal digits.
// ----------------------------------------------------------------------------
package clws_pkg;

    // Width of the duration registers.
    localparam int CFG_TICK_W = 20;

    // Opcodes of the input item.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_INIT  = 3'd1;
    localparam logic [2:0] OP_CMD   = 3'd2;
    localparam logic [2:0] OP_CHAR  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Item classes after decoding; unknown opcodes fold into ticks.
    localparam logic [2:0] CLS_TICK = 3'd0;
    localparam logic [2:0] CLS_INIT = 3'd1;
    localparam logic [2:0] CLS_CMD  = 3'd2;
    localparam logic [2:0] CLS_CHAR = 3'd3;
    localparam logic [2:0] CLS_READ = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_FUNCTION_SET = 3'd0;
    localparam logic [2:0] REG_CLEAR        = 3'd1;
    localparam logic [2:0] REG_ENTRY_MODE   = 3'd2;
    localparam logic [2:0] REG_DISPLAY_ON   = 3'd3;
    localparam logic [2:0] REG_SETUP        = 3'd4;
    localparam logic [2:0] REG_SHORT_WAIT   = 3'd5;
    localparam logic [2:0] REG_LONG_WAIT    = 3'd6;

    // Register reset values.
    localparam logic [7:0]            RST_FUNCTION_SET = 8'd56;
    localparam logic [7:0]            RST_CLEAR        = 8'd1;
    localparam logic [7:0]            RST_ENTRY_MODE   = 8'd6;
    localparam logic [7:0]            RST_DISPLAY_ON   = 8'd12;
    localparam logic [CFG_TICK_W-1:0] RST_SETUP        = 20'd25;
    localparam logic [CFG_TICK_W-1:0] RST_SHORT_WAIT   = 20'd2000;
    localparam logic [CFG_TICK_W-1:0] RST_LONG_WAIT    = 20'd76500;

    // Largest reading that can be shown.
    localparam logic [13:0] READING_MAX = 14'd9999;

    // Reciprocals: x / 1000 = (x * 8389) >> 23 for x <= 9999,
    // x / 100 = (x * 41) >> 12 for x < 1000, x / 10 = (x * 205) >> 11 for x < 100.
    localparam logic [13:0] RECIP_1000 = 14'd8389;
    localparam logic [5:0]  RECIP_100  = 6'd41;
    localparam logic [7:0]  RECIP_10   = 8'd205;

    // Characters of the reading display.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_UNIT  = 8'h67;

    // Depth of the queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  byte_value;
        logic [15:0] reading;
    } clws_in_t;

    typedef struct packed {
        logic       pin_rs;
        logic       pin_rw;
        logic       pin_e;
        logic [7:0] pin_data;
        logic       busy_res;
        logic       rejected;
    } clws_out_t;

    // One classified item as the back end sees it.
    typedef struct packed {
        logic [2:0] cls;
        logic [7:0] byte_value;
        logic [3:0] digit_thou;
        logic [3:0] digit_hund;
        logic [3:0] digit_tens;
        logic [3:0] digit_ones;
    } clws_cmd_t;

    typedef struct packed {
        logic [7:0]            function_set_cmd;
        logic [7:0]            clear_cmd;
        logic [7:0]            entry_mode_cmd;
        logic [7:0]            display_on_cmd;
        logic [CFG_TICK_W-1:0] setup_ticks;
        logic [CFG_TICK_W-1:0] short_wait_ticks;
        logic [CFG_TICK_W-1:0] long_wait_ticks;
    } clws_cfg_t;

endpackage

[src/clws_front.sv]
// ----------------------------------------------------------------------------
// clws_front: item decoder
// Accepts input items, classifies the opcode and splits a saturated reading
// into four decimal digits over two pipeline stages.
// ----------------------------------------------------------------------------
module clws_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  clws_pkg::clws_in_t  in_item,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output clws_pkg::clws_cmd_t cmd
);
    import clws_pkg::*;

    logic        s1_valid_reg;
    logic [2:0]  s1_cls_reg;
    logic [7:0]  s1_byte_reg;
    logic [13:0] s1_sat_reg;
    logic [3:0]  s1_thou_reg;

    logic        s2_valid_reg;
    logic [2:0]  s2_cls_reg;
    logic [7:0]  s2_byte_reg;
    logic [3:0]  s2_thou_reg;
    logic [3:0]  s2_hund_reg;
    logic [9:0]  s2_rem_reg;

    logic        s1_load;
    logic        s2_load;
    logic [2:0]  cls_in;
    logic [13:0] sat_in;
    logic [26:0] prod_thou;
    logic [13:0] rem_thou;
    logic [15:0] prod_hund;
    logic [9:0]  rem_hund;
    logic [6:0]  rem_hund_n;
    logic [14:0] prod_tens;
    logic [3:0]  tens_digit;
    logic [6:0]  rem_tens;

    // A stage takes new data when it is empty or its content moves on.
    assign s2_load  = !s2_valid_reg || cmd_ready;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_ready = s1_load;

    always_comb
    begin
        unique case (in_item.opcode)
            OP_INIT: cls_in = CLS_INIT;
            OP_CMD:  cls_in = CLS_CMD;
            OP_CHAR: cls_in = CLS_CHAR;
            OP_READ: cls_in = CLS_READ;
            default: cls_in = CLS_TICK;
        endcase
    end

    assign sat_in    = (in_item.reading > 16'(READING_MAX)) ? READING_MAX
                                                            : in_item.reading[13:0];
    assign prod_thou = 27'(sat_in) * 27'(RECIP_1000);

    assign rem_thou  = s1_sat_reg - 14'(s1_thou_reg) * 14'd1000;
    assign prod_hund = 16'(rem_thou[9:0]) * 16'(RECIP_100);

    assign rem_hund   = s2_rem_reg - 10'(s2_hund_reg) * 10'd100;
    assign rem_hund_n = rem_hund[6:0];
    assign prod_tens  = 15'(rem_hund_n) * 15'(RECIP_10);
    assign tens_digit = prod_tens[14:11];
    assign rem_tens   = rem_hund_n - 7'(tens_digit) * 7'd10;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_cls_reg  <= cls_in;
            s1_byte_reg <= in_item.byte_value;
            s1_sat_reg  <= sat_in;
            s1_thou_reg <= prod_thou[26:23];
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_cls_reg  <= s1_cls_reg;
            s2_byte_reg <= s1_byte_reg;
            s2_thou_reg <= s1_thou_reg;
            s2_hund_reg <= prod_hund[15:12];
            s2_rem_reg  <= rem_thou[9:0];
        end
    end

    assign cmd_valid       = s2_valid_reg;
    assign cmd.cls         = s2_cls_reg;
    assign cmd.byte_value  = s2_byte_reg;
    assign cmd.digit_thou  = s2_thou_reg;
    assign cmd.digit_hund  = s2_hund_reg;
    assign cmd.digit_tens  = tens_digit;
    assign cmd.digit_ones  = rem_tens[3:0];

endmodule

[src/clws_queue.sv]
// ----------------------------------------------------------------------------
// clws_queue: short queue between decoder and sequencer
// A small register FIFO so that the decoder and the sequencer stall apart.
// ----------------------------------------------------------------------------
module clws_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  clws_pkg::clws_cmd_t push_cmd,
    output logic                pop_valid,
    input  logic                pop_ready,
    output clws_pkg::clws_cmd_t pop_cmd
);
    import clws_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    clws_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign push_ready = count_reg != COUNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[src/clws_back.sv]
// ----------------------------------------------------------------------------
// clws_back: bus sequencer
// Carries out one classified item per cycle unless the output stalls: starts
// sequences, counts ticks, drives RS, E and the data lines, and registers one
// result per item.
module clws_back #(
    parameter int TICK_COUNT_BITS = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  clws_pkg::clws_cfg_t cfg,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  clws_pkg::clws_cmd_t cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output clws_pkg::clws_out_t out_item
);
    import clws_pkg::*;

    localparam int CNT_W = TICK_COUNT_BITS;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_PRE    = 3'd1;
    localparam logic [2:0] PH_SETUP  = 3'd2;
    localparam logic [2:0] PH_PULSE  = 3'd3;
    localparam logic [2:0] PH_SETTLE = 3'd4;
    localparam logic [2:0] PH_EXTRA  = 3'd5;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_INIT    = 2'd1;
    localparam logic [1:0] KIND_SINGLE  = 2'd2;
    localparam logic [1:0] KIND_READING = 2'd3;

    localparam logic [2:0] INIT_COUNT       = 3'd5;
    localparam logic [2:0] READING_COUNT    = 3'd6;
    localparam logic [2:0] IDX_FIRST_CLEAR  = 3'd1;
    localparam logic [2:0] IDX_SECOND_CLEAR = 3'd4;

    localparam logic [32:0] CNT_LIMIT = (33'd1 << CNT_W) - 33'd1;

    logic [2:0]       phase_reg,       phase_next;
    logic [CNT_W-1:0] countdown_reg,   countdown_next;
    logic [7:0]       out_byte_reg,    out_byte_next;
    logic             rs_reg,          rs_next;
    logic             e_reg,           e_next;
    logic [1:0]       kind_reg,        kind_next;
    logic [2:0]       index_reg,       index_next;
    logic [15:0]      digits_reg,      digits_next;
    logic [7:0]       single_byte_reg, single_byte_next;
    logic             out_valid_reg,   out_valid_next;
    clws_out_t        result_reg,      result_next;

    logic             take;
    logic             rejected;
    logic [2:0]       index_inc;
    logic [CNT_W-1:0] dur_setup;
    logic [CNT_W-1:0] dur_short;
    logic [CNT_W-1:0] dur_long;
    logic [7:0]       pending;

    // Durations saturate at the counter's range, and zero counts as one tick.
    function automatic logic [CNT_W-1:0] dur(input logic [CFG_TICK_W-1:0] v);
        logic [32:0] wide;
        wide = 33'(v);
        if (wide > CNT_LIMIT)
        begin
            wide = CNT_LIMIT;
        end
        if (wide == 33'd0)
        begin
            wide = 33'd1;
        end
        return wide[CNT_W-1:0];
    endfunction

    assign dur_setup = dur(cfg.setup_ticks);
    assign dur_short = dur(cfg.short_wait_ticks);
    assign dur_long  = dur(cfg.long_wait_ticks);

    always_comb
    begin
        if (kind_reg == KIND_SINGLE)
        begin
            pending = single_byte_reg;
        end
        else if (kind_reg == KIND_READING)
        begin
            unique case (index_reg)
                3'd0:    pending = CHAR_ZERO + 8'(digits_reg[15:12]);
                3'd1:    pending = CHAR_POINT;
                3'd2:    pending = CHAR_ZERO + 8'(digits_reg[11:8]);
                3'd3:    pending = CHAR_ZERO + 8'(digits_reg[7:4]);
                3'd4:    pending = CHAR_ZERO + 8'(digits_reg[3:0]);
                default: pending = CHAR_UNIT;
            endcase
        end
        else
        begin
            unique case (index_reg)
                3'd0:    pending = cfg.function_set_cmd;
                3'd1:    pending = cfg.clear_cmd;
                3'd2:    pending = cfg.entry_mode_cmd;
                3'd3:    pending = cfg.display_on_cmd;
                default: pending = cfg.clear_cmd;
            endcase
        end
    end

    assign take      = cmd_valid && (!out_valid_reg || out_ready);
    assign cmd_ready = !out_valid_reg || out_ready;
    assign index_inc = index_reg + 3'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        countdown_next   = countdown_reg;
        out_byte_next    = out_byte_reg;
        rs_next          = rs_reg;
        e_next           = e_reg;
        kind_next        = kind_reg;
        index_next       = index_reg;
        digits_next      = digits_reg;
        single_byte_next = single_byte_reg;
        rejected         = 1'b0;

        if (take)
        begin
            if (cmd.cls != CLS_TICK)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    index_next = 3'd0;
                    unique case (cmd.cls)
                        CLS_INIT:
                        begin
                            kind_next      = KIND_INIT;
                            phase_next     = PH_PRE;
                            countdown_next = dur_short;
                        end
                        CLS_READ:
                        begin
                            kind_next      = KIND_READING;
                            digits_next    = {cmd.digit_thou, cmd.digit_hund,
                                              cmd.digit_tens, cmd.digit_ones};
                            phase_next     = PH_SETUP;
                            rs_next        = 1'b1;
                            e_next         = 1'b0;
                            countdown_next = dur_setup;
                        end
                        default:
                        begin
                            kind_next        = KIND_SINGLE;
                            single_byte_next = cmd.byte_value;
                            phase_next       = PH_SETUP;
                            rs_next          = cmd.cls == CLS_CHAR;
                            e_next           = 1'b0;
                            countdown_next   = dur_setup;
                        end
                    endcase
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (countdown_reg != CNT_W'(1))
                begin
                    countdown_next = countdown_reg - CNT_W'(1);
                end
                else
                begin
                    unique case (phase_reg)
                        PH_PRE:
                        begin
                            // Init always drives commands with RS low.
                            phase_next     = PH_SETUP;
                            rs_next        = 1'b0;
                            e_next         = 1'b0;
                            countdown_next = dur_setup;
                        end
                        PH_SETUP:
                        begin
                            phase_next     = PH_PULSE;
                            e_next         = 1'b1;
                            out_byte_next  = pending;
                            countdown_next = dur_setup;
                        end
                        PH_PULSE:
                        begin
                            phase_next     = PH_SETTLE;
                            e_next         = 1'b0;
                            countdown_next = dur_short;
                        end
                        PH_SETTLE:
                        begin
                            if (kind_reg == KIND_INIT || kind_reg == KIND_READING)
                            begin
                                phase_next = PH_EXTRA;
                                // Both clear commands need the long wait.
                                if (kind_reg == KIND_INIT &&
                                    (index_reg == IDX_FIRST_CLEAR ||
                                     index_reg == IDX_SECOND_CLEAR))
                                begin
                                    countdown_next = dur_long;
                                end
                                else
                                begin
                                    countdown_next = dur_short;
                                end
                            end
                            else
                            begin
                                phase_next     = PH_IDLE;
                                kind_next      = KIND_NONE;
                                index_next     = 3'd0;
                                countdown_next = '0;
                            end
                        end
                        PH_EXTRA:
                        begin
                            if (kind_reg == KIND_NONE || kind_reg == KIND_SINGLE ||
                                (kind_reg == KIND_INIT && index_inc >= INIT_COUNT) ||
                                (kind_reg == KIND_READING && index_inc >= READING_COUNT))
                            begin
                                phase_next     = PH_IDLE;
                                kind_next      = KIND_NONE;
                                index_next     = 3'd0;
                                countdown_next = '0;
                            end
                            else
                            begin
                                index_next     = index_inc;
                                phase_next     = PH_SETUP;
                                rs_next        = kind_reg == KIND_READING;
                                e_next         = 1'b0;
                                countdown_next = dur_setup;
                            end
                        end
                        default:
                        begin
                            phase_next     = PH_IDLE;
                            kind_next      = KIND_NONE;
                            index_next     = 3'd0;
                            countdown_next = '0;
                        end
                    endcase
                end
            end
        end

        result_next.pin_rs   = rs_next;
        result_next.pin_rw   = 1'b0;
        result_next.pin_e    = e_next;
        result_next.pin_data = out_byte_next;
        result_next.busy_res = phase_next != PH_IDLE;
        result_next.rejected = rejected;

        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            countdown_reg <= '0;
            out_byte_reg  <= 8'd0;
            rs_reg        <= 1'b0;
            e_reg         <= 1'b0;
            kind_reg      <= KIND_NONE;
            index_reg     <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            countdown_reg <= countdown_next;
            out_byte_reg  <= out_byte_next;
            rs_reg        <= rs_next;
            e_reg         <= e_next;
            kind_reg      <= kind_next;
            index_reg     <= index_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg      <= digits_next;
        single_byte_reg <= single_byte_next;
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = result_reg;

endmodule

[src/char_lcd_write_sequencer.sv]
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer: 8-bit character LCD write bus driver
// Runs init, command, character and reading sequences on an 8-bit LCD bus,
// advanced by tick items, with one result item per input item.
// ----------------------------------------------------------------------------
// Every input item, tick or request, yields exactly one result item that shows
// the bus lines and busy flag after that item. The block sustains one transfer
// per clock cycle unless the output stalls: the sequencer updates its phase
// counter once per item and each item needs only one decrement and compare.
// A result passes through two decode stages that split a reading into digits
// with reciprocal multiplies, the queue, and the result register, the first of
// which loads at the edge that accepts its item; the two-entry queue and the
// result register let either side stall without losing items.
// Requests that arrive while a sequence runs are dropped and flagged as
// rejected. Configuration writes are always accepted and should be made only
// while no item is in flight.
module char_lcd_write_sequencer #(
    parameter int TICK_COUNT_BITS = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  clws_pkg::clws_in_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output clws_pkg::clws_out_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [19:0]         cfg_data
);
    import clws_pkg::*;

    clws_cfg_t cfg_reg;

    logic      front_valid;
    logic      front_ready;
    clws_cmd_t front_cmd;
    logic      queue_valid;
    logic      queue_ready;
    clws_cmd_t queue_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.function_set_cmd <= RST_FUNCTION_SET;
            cfg_reg.clear_cmd        <= RST_CLEAR;
            cfg_reg.entry_mode_cmd   <= RST_ENTRY_MODE;
            cfg_reg.display_on_cmd   <= RST_DISPLAY_ON;
            cfg_reg.setup_ticks      <= RST_SETUP;
            cfg_reg.short_wait_ticks <= RST_SHORT_WAIT;
            cfg_reg.long_wait_ticks  <= RST_LONG_WAIT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FUNCTION_SET: cfg_reg.function_set_cmd <= cfg_data[7:0];
                REG_CLEAR:        cfg_reg.clear_cmd        <= cfg_data[7:0];
                REG_ENTRY_MODE:   cfg_reg.entry_mode_cmd   <= cfg_data[7:0];
                REG_DISPLAY_ON:   cfg_reg.display_on_cmd   <= cfg_data[7:0];
                REG_SETUP:        cfg_reg.setup_ticks      <= cfg_data;
                REG_SHORT_WAIT:   cfg_reg.short_wait_ticks <= cfg_data;
                REG_LONG_WAIT:    cfg_reg.long_wait_ticks  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    clws_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    clws_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_cmd    (queue_cmd)
    );

    clws_back #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // A request is only dropped while a sequence runs, and the drop itself
    // leaves that sequence running.
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.rejected |-> out_item.busy_res)
        else $error("rejected result without a running sequence");

    // The enable strobe is only high inside a sequence.
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.pin_e |-> out_item.busy_res)
        else $error("enable high while idle");

    // A transfer from the queue into the back end needs room at the output.
    a_back_room: assert property (@(posedge clk) disable iff (!rst_n)
        queue_valid && queue_ready |-> !out_valid || out_ready)
        else $error("sequencer took an item with a blocked result register");

endmodule
